### rtl/okl_pkg.sv
`timescale 1ns / 1ps

package okl_pkg;

	// Channel field widths
	localparam int CMD_W   = 3;
	localparam int POS_W   = 7;
	localparam int KEY_W   = 64;
	localparam int STS_W   = 2;
	localparam int FPOS_W  = 6;
	localparam int CNT_O_W = 7;

	// Default sizing
	localparam int OKL_CAPACITY = 64;
	localparam int OKL_KEY_BITS = 64;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL_AT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_KEY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LIST    = 3'd5;

	// Result status codes
	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_BADPOS   = 2'd1;
	localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL     = 2'd3;

endpackage

### rtl/okl_cmd_if.sv
`timescale 1ns / 1ps

interface okl_cmd_if
	import okl_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [POS_W-1:0] position;
	logic [KEY_W-1:0] key;

	modport source (output valid, command, position, key, input ready);
	modport sink (input valid, command, position, key, output ready);
endinterface

### rtl/okl_rsp_if.sv
`timescale 1ns / 1ps

interface okl_rsp_if
	import okl_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [STS_W-1:0]   status;
	logic [FPOS_W-1:0]  found_position;
	logic [KEY_W-1:0]   entry_key;
	logic [CNT_O_W-1:0] entry_count;
	logic               last;

	modport source (output valid, status, found_position, entry_key, entry_count, last,
		input ready);
	modport sink (input valid, status, found_position, entry_key, entry_count, last,
		output ready);
endinterface

### rtl/ordered_key_list_engine.sv
`timescale 1ns / 1ps
// Ordered key list engine.
// cmd carries one command transaction (clear, insert at, delete at, delete by key,
// search, list all); rsp returns result transactions, the final one of each
// command marked by last. Codes six and seven are taken and dropped without result.
// The list sits in one synchronous memory of CAPACITY entries with one write and
// one registered read port; every shift and search walks it one entry a cycle.
// cmd is ready only while the engine is idle. Command flow after acceptance:
//   clear, rejected commands, empty list: straight to the result stage.
//   insert/delete at: shift the entries behind the position, then commit the count.
//   search: scan from the head to hit or end; delete by key adds the shift behind it.
//   list all: read the first entry, then one result per cycle while rsp is ready.
// A new command may be accepted while the last result still waits in the output
// register. When rsp stalls, the result register holds and the engine waits;
// listing resumes from the held entry.
// Reset (arst_n low) empties the list (count zero) and drops any pending result.
// The memory is not cleared; entries at or above count never reach a result.

module ordered_key_list_engine
	import okl_pkg::*;
	#(
	parameter int CAPACITY = OKL_CAPACITY,
	parameter int KEY_BITS = OKL_KEY_BITS
	) (
	input  logic      clk,
	input  logic      arst_n,
	okl_cmd_if.sink   cmd,
	okl_rsp_if.source rsp
	);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_MOVE     = 3'd2;
	localparam logic [2:0] S_FINISH   = 3'd3;
	localparam logic [2:0] S_EMIT     = 3'd4;
	localparam logic [2:0] S_LIST_RD  = 3'd5;
	localparam logic [2:0] S_LIST_OUT = 3'd6;

	logic [KEY_BITS-1:0] mem_q [CAPACITY];
	logic [KEY_BITS-1:0] rdata_q;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [IDX_W-1:0]    pos_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [IDX_W-1:0]    end_q;
	logic                more_q;
	logic                up_q;
	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [STS_W-1:0]    res_status_q;
	logic [IDX_W-1:0]    res_pos_q;

	logic                out_valid_q;
	logic [STS_W-1:0]    out_status_q;
	logic [FPOS_W-1:0]   out_pos_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [CNT_O_W-1:0]  out_count_q;
	logic                out_last_q;

	logic                out_free;
	logic [CNT_W-1:0]    last_idx;
	logic                list_last;
	logic [IDX_W-1:0]    rd_addr;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [KEY_BITS-1:0] mem_wd;
	logic [CNT_O_W-1:0]  cnt_ext;

	assign out_free  = !out_valid_q || rsp.ready;
	assign last_idx  = count_q - CNT_W'(1);
	assign list_last = (CNT_W'(ptr_q) == last_idx);
	assign cnt_ext   = CNT_O_W'(count_q);

	// Advance the read address early while listing so one entry leaves per cycle while the output is free
	always_comb begin
		if (state_q == S_LIST_OUT && out_free && !list_last) begin
			rd_addr = ptr_q + IDX_W'(1);
		end else begin
			rd_addr = ptr_q;
		end
	end

	// Write port: shifted entries during a move, the new key at the end of an insert
	always_comb begin
		if (state_q == S_FINISH) begin
			mem_we = (cmd_q == CMD_INSERT);
			mem_wa = pos_q;
			mem_wd = key_q;
		end else begin
			mem_we = (state_q == S_MOVE) && v_s1;
			mem_wa = idx_s1;
			mem_wd = rdata_q;
		end
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// Command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			cmd_q        <= CMD_CLEAR;
			pos_q        <= '0;
			key_q        <= '0;
			ptr_q        <= '0;
			end_q        <= '0;
			more_q       <= 1'b0;
			up_q         <= 1'b0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			res_status_q <= STS_OK;
			res_pos_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			out_pos_q    <= '0;
			out_key_q    <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: if (cmd.valid) begin
					cmd_q     <= cmd.command;
					pos_q     <= IDX_W'(cmd.position);
					key_q     <= cmd.key[KEY_BITS-1:0];
					res_pos_q <= '0;
					v_s1      <= 1'b0;
					case (cmd.command)
						CMD_CLEAR: begin
							count_q      <= '0;
							res_status_q <= STS_OK;
							state_q      <= S_EMIT;
						end
						CMD_INSERT: begin
							if (cmd.position > cnt_ext) begin
								res_status_q <= STS_BADPOS;
								state_q      <= S_EMIT;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								res_status_q <= STS_FULL;
								state_q      <= S_EMIT;
							end else if (cmd.position == cnt_ext) begin
								state_q <= S_FINISH;
							end else begin
								ptr_q   <= IDX_W'(last_idx);
								end_q   <= IDX_W'(cmd.position);
								more_q  <= 1'b1;
								up_q    <= 1'b1;
								state_q <= S_MOVE;
							end
						end
						CMD_DEL_AT: begin
							if (cmd.position >= cnt_ext) begin
								res_status_q <= STS_BADPOS;
								state_q      <= S_EMIT;
							end else if (cmd.position + POS_W'(1) == cnt_ext) begin
								state_q <= S_FINISH;
							end else begin
								ptr_q   <= IDX_W'(cmd.position) + IDX_W'(1);
								end_q   <= IDX_W'(last_idx);
								more_q  <= 1'b1;
								up_q    <= 1'b0;
								state_q <= S_MOVE;
							end
						end
						CMD_DEL_KEY, CMD_SEARCH: begin
							if (count_q == '0) begin
								res_status_q <= STS_NOTFOUND;
								state_q      <= S_EMIT;
							end else begin
								ptr_q   <= '0;
								end_q   <= IDX_W'(last_idx);
								more_q  <= 1'b1;
								state_q <= S_SCAN;
							end
						end
						CMD_LIST: begin
							if (count_q == '0) begin
								res_status_q <= STS_NOTFOUND;
								state_q      <= S_EMIT;
							end else begin
								ptr_q   <= '0;
								state_q <= S_LIST_RD;
							end
						end
						default: begin
							// Drop unused codes
						end
					endcase
				end

				S_SCAN: begin
					// Issue the next read, compare the previous one
					if (more_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= ptr_q;
						if (ptr_q == end_q) begin
							more_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + IDX_W'(1);
						end
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (rdata_q == key_q) begin
							v_s1      <= 1'b0;
							more_q    <= 1'b0;
							res_pos_q <= idx_s1;
							if (cmd_q == CMD_SEARCH) begin
								res_status_q <= STS_OK;
								state_q      <= S_EMIT;
							end else if (CNT_W'(idx_s1) == last_idx) begin
								state_q <= S_FINISH;
							end else begin
								ptr_q   <= idx_s1 + IDX_W'(1);
								end_q   <= IDX_W'(last_idx);
								more_q  <= 1'b1;
								up_q    <= 1'b0;
								state_q <= S_MOVE;
							end
						end else if (CNT_W'(idx_s1) == last_idx) begin
							v_s1         <= 1'b0;
							res_status_q <= STS_NOTFOUND;
							state_q      <= S_EMIT;
						end
					end
				end

				S_MOVE: begin
					// Read one entry per cycle, write it one slot over the next cycle
					if (more_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= up_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
						if (ptr_q == end_q) begin
							more_q <= 1'b0;
						end else begin
							ptr_q <= up_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
						end
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1 && !more_q) begin
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					// Commit the count change; the insert key is written this cycle
					if (cmd_q == CMD_INSERT) begin
						count_q <= count_q + CNT_W'(1);
					end else begin
						count_q <= last_idx;
					end
					res_status_q <= STS_OK;
					state_q      <= S_EMIT;
				end

				S_EMIT: if (out_free) begin
					out_valid_q  <= 1'b1;
					out_status_q <= res_status_q;
					out_pos_q    <= FPOS_W'(res_pos_q);
					out_key_q    <= '0;
					out_count_q  <= cnt_ext;
					out_last_q   <= 1'b1;
					state_q      <= S_IDLE;
				end

				S_LIST_RD: begin
					state_q <= S_LIST_OUT;
				end

				S_LIST_OUT: if (out_free) begin
					out_valid_q  <= 1'b1;
					out_status_q <= STS_OK;
					out_pos_q    <= FPOS_W'(ptr_q);
					out_key_q    <= KEY_W'(rdata_q);
					out_count_q  <= cnt_ext;
					out_last_q   <= list_last;
					if (list_last) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_pos_q;
	assign rsp.entry_key      = out_key_q;
	assign rsp.entry_count    = out_count_q;
	assign rsp.last           = out_last_q;

endmodule

### tb/sv/tb_ordered_key_list_engine.sv
`timescale 1ns / 1ps

module tb_ordered_key_list_engine;
	import okl_pkg::*;

	localparam int LIST_DEPTH = OKL_CAPACITY;
	localparam int KEY_LEN    = OKL_KEY_BITS;
	localparam logic [KEY_W-1:0] KEY_MASK =
		(KEY_LEN >= KEY_W) ? '1 : ((64'd1 << KEY_LEN) - 64'd1);

	// Command codes the engine takes and drops without a result
	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

	// Cycles to let pass after the last result before the verdict
	localparam int DRAIN_CYCLES = LIST_DEPTH + 16;

	typedef struct packed {
		logic [STS_W-1:0]   status;
		logic [FPOS_W-1:0]  found_position;
		logic [KEY_W-1:0]   entry_key;
		logic [CNT_O_W-1:0] entry_count;
		logic               last;
	} list_result_t;

	logic clk;
	logic arst_n = 1'b0;

	okl_cmd_if cmd_ch ();
	okl_rsp_if rsp_ch ();

	ordered_key_list_engine #(
		.CAPACITY(LIST_DEPTH),
		.KEY_BITS(KEY_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the list
	logic [KEY_W-1:0] shadow_keys [LIST_DEPTH];
	int               shadow_len = 0;

	list_result_t pending_results [$];
	int           error_count = 0;
	bit           idling_on = 1'b1;
	int           stall_left = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case the engine hangs
	initial begin
		#(20_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	// Queue one expected result; entry_count is the length after the command
	function automatic void add_result(logic [STS_W-1:0] status, int fpos,
			logic [KEY_W-1:0] ekey, bit last);
		list_result_t r;
		r.status         = status;
		r.found_position = FPOS_W'(fpos);
		r.entry_key      = ekey;
		r.entry_count    = CNT_O_W'(shadow_len);
		r.last           = last;
		pending_results.push_back(r);
	endfunction

	function automatic int find_first_key(logic [KEY_W-1:0] k);
		int i;
		for (i = 0; i < shadow_len; i++)
			if (shadow_keys[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void remove_entry(int at);
		int i;
		for (i = at; i + 1 < shadow_len; i++)
			shadow_keys[i] = shadow_keys[i + 1];
		shadow_len--;
	endfunction

	// Update the shadow list for one accepted command and queue its results
	function automatic void predict_list_command(logic [CMD_W-1:0] c,
			logic [POS_W-1:0] p, logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] mk;
		int               at;
		int               i;
		mk = k & KEY_MASK;
		at = int'(p);
		case (c)
			CMD_CLEAR: begin
				shadow_len = 0;
				add_result(STS_OK, 0, '0, 1'b1);
			end
			CMD_INSERT: begin
				if (at > shadow_len) begin
					add_result(STS_BADPOS, 0, '0, 1'b1);
				end else if (shadow_len >= LIST_DEPTH) begin
					add_result(STS_FULL, 0, '0, 1'b1);
				end else begin
					for (i = shadow_len; i > at; i--)
						shadow_keys[i] = shadow_keys[i - 1];
					shadow_keys[at] = mk;
					shadow_len++;
					add_result(STS_OK, 0, '0, 1'b1);
				end
			end
			CMD_DEL_AT: begin
				if (at >= shadow_len) begin
					add_result(STS_BADPOS, 0, '0, 1'b1);
				end else begin
					remove_entry(at);
					add_result(STS_OK, 0, '0, 1'b1);
				end
			end
			CMD_DEL_KEY: begin
				i = find_first_key(mk);
				if (i < 0) begin
					add_result(STS_NOTFOUND, 0, '0, 1'b1);
				end else begin
					remove_entry(i);
					add_result(STS_OK, i, '0, 1'b1);
				end
			end
			CMD_SEARCH: begin
				i = find_first_key(mk);
				if (i < 0)
					add_result(STS_NOTFOUND, 0, '0, 1'b1);
				else
					add_result(STS_OK, i, '0, 1'b1);
			end
			CMD_LIST: begin
				if (shadow_len == 0)
					add_result(STS_NOTFOUND, 0, '0, 1'b1);
				else
					for (i = 0; i < shadow_len; i++)
						add_result(STS_OK, i, shadow_keys[i], i + 1 == shadow_len);
			end
			default: begin
			end
		endcase
	endfunction

	// Drive one command transaction and hold it until the engine takes it
	task automatic send_command(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
			logic [KEY_W-1:0] k);
		int gap;
		@(negedge clk);
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.command  <= c;
		cmd_ch.position <= p;
		cmd_ch.key      <= k;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predict_list_command(c, p, k);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50 && shadow_len > 0)
			return shadow_keys[$urandom_range(0, shadow_len - 1)];
		if (roll < 75)
			return KEY_W'($urandom_range(1, 6));
		return {$urandom, $urandom};
	endfunction

	// Mostly in range, sometimes any 7-bit position
	function automatic logic [POS_W-1:0] pick_position(int hi);
		if ($urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, (hi < 0) ? 0 : hi));
		return POS_W'($urandom);
	endfunction

	task automatic send_random_command();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 38)
			send_command(CMD_INSERT, pick_position(shadow_len), pick_key());
		else if (roll < 52)
			send_command(CMD_DEL_AT, pick_position(shadow_len - 1), pick_key());
		else if (roll < 64)
			send_command(CMD_DEL_KEY, POS_W'($urandom), pick_key());
		else if (roll < 80)
			send_command(CMD_SEARCH, POS_W'($urandom), pick_key());
		else if (roll < 87)
			send_command(CMD_LIST, POS_W'($urandom), {$urandom, $urandom});
		else if (roll < 90)
			send_command(CMD_CLEAR, POS_W'($urandom), {$urandom, $urandom});
		else if (roll < 93)
			send_command($urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6,
				POS_W'($urandom), {$urandom, $urandom});
		else
			send_command(CMD_INSERT, POS_W'($urandom), pick_key());
	endtask

	task automatic test_empty_list();
		send_command(CMD_LIST, '0, '0);
		send_command(CMD_SEARCH, '0, 64'h1);
		send_command(CMD_DEL_AT, '0, '0);
		send_command(CMD_DEL_KEY, '0, 64'h1);
		send_command(CMD_INSERT, 7'd1, 64'h1);
		send_command(CMD_INSERT, 7'd127, 64'h1);
	endtask

	task automatic test_insert_shift();
		send_command(CMD_INSERT, 7'd0, 64'h0);
		send_command(CMD_INSERT, 7'd1, '1);
		send_command(CMD_INSERT, 7'd0, 64'h0000_0000_6e61_6d65);
		send_command(CMD_INSERT, 7'd2, 64'hA5A5_5A5A_0F0F_F0F0);
		send_command(CMD_INSERT, 7'd5, 64'h1234);
		// duplicate key at the end: search must still hit the first one
		send_command(CMD_INSERT, 7'd4, 64'h0000_0000_6e61_6d65);
		send_command(CMD_SEARCH, '0, 64'h0000_0000_6e61_6d65);
		send_command(CMD_SEARCH, '0, '1);
		send_command(CMD_SEARCH, '0, 64'hDEAD_BEEF);
		send_command(CMD_LIST, '0, '0);
	endtask

	task automatic test_delete();
		send_command(CMD_DEL_KEY, '0, 64'h0000_0000_6e61_6d65);
		send_command(CMD_DEL_AT, POS_W'(shadow_len - 1), '0);
		send_command(CMD_DEL_AT, POS_W'(shadow_len), '0);
		send_command(CMD_DEL_AT, 7'd64, '0);
		send_command(CMD_UNUSED_6, 7'd0, '1);
		send_command(CMD_UNUSED_7, 7'd127, '0);
		send_command(CMD_LIST, '0, '0);
		send_command(CMD_CLEAR, '0, '0);
		send_command(CMD_LIST, '0, '0);
	endtask

	task automatic test_full_list();
		int n;
		send_command(CMD_CLEAR, '0, '0);
		for (n = 0; n < LIST_DEPTH; n++)
			send_command(CMD_INSERT, POS_W'($urandom_range(0, shadow_len)), pick_key());
		send_command(CMD_INSERT, POS_W'(shadow_len), 64'h77);
		send_command(CMD_INSERT, POS_W'(shadow_len + 1), 64'h77);
		send_command(CMD_INSERT, 7'd0, 64'h77);
		send_command(CMD_LIST, '0, '0);
		send_command(CMD_SEARCH, '0, shadow_keys[LIST_DEPTH - 1]);
		send_command(CMD_DEL_AT, POS_W'(LIST_DEPTH - 1), '0);
		send_command(CMD_DEL_AT, POS_W'(LIST_DEPTH - 1), '0);
		send_command(CMD_DEL_AT, 7'd0, '0);
		send_command(CMD_LIST, '0, '0);
	endtask

	task automatic test_random_mix();
		int n;
		for (n = 0; n < 80; n++)
			send_random_command();
	endtask

	task automatic test_back_to_back();
		int n;
		idling_on = 1'b0;
		for (n = 0; n < 30; n++)
			send_random_command();
	endtask

	// Drop ready for random bursts while idling is on
	always @(negedge clk) begin
		if (!idling_on) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [KEY_W-1:0] want,
			logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with none expected: status %0d, count %0d",
					rsp_ch.status, rsp_ch.entry_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", KEY_W'(want.status), KEY_W'(rsp_ch.status));
				check_field("found_position", KEY_W'(want.found_position),
					KEY_W'(rsp_ch.found_position));
				check_field("entry_key", want.entry_key, rsp_ch.entry_key);
				check_field("entry_count", KEY_W'(want.entry_count),
					KEY_W'(rsp_ch.entry_count));
				check_field("last", KEY_W'(want.last), KEY_W'(rsp_ch.last));
			end
		end
	end

	initial begin : run_tests
		int waited;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.command  <= CMD_CLEAR;
		cmd_ch.position <= '0;
		cmd_ch.key      <= '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_insert_shift();
		test_delete();
		test_full_list();
		test_random_mix();
		test_back_to_back();

		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result transactions never arrived",
				pending_results.size());
			error_count++;
		end

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
